// File: src/spr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// spr_pkg: shared types and constants of the polyphase resampler
// Sizes, command and status codes, and the controller-to-datapath interface.
// ============================================================================
package spr_pkg;

    localparam int PHASES      = 64;
    localparam int MAX_HALF    = 32;
    localparam int HIST_DEPTH  = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int COEF_FRAC   = COEF_BITS - 2;
    localparam int RATE_BITS   = 18;
    localparam int HALF_BITS   = 6;
    localparam int CNT_BITS    = 48;
    localparam int TAP_BITS    = $clog2(2 * MAX_HALF + 2);
    localparam int PHASE_BITS  = $clog2(PHASES);
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int COEF_DEPTH  = PHASES * (2 * MAX_HALF + 1);
    localparam int COEF_AW     = 13;
    localparam int ACC_BITS    = 48;
    localparam int MAX_RUN     = 64;
    localparam int RUN_BITS    = $clog2(MAX_RUN + 1);
    localparam int CFG_AW      = 2;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_FLUSH   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_COEF_WR = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_TRUNC  = 2'd2
    } status_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SOURCE_RATE = 2'd0,
        CFG_TARGET_RATE = 2'd1,
        CFG_HALF_WIDTH  = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_PUSH,
        DP_RESTART,
        DP_COEF_WR,
        DP_SYNC_IDX,
        DP_DUE_START,
        DP_PH_START,
        DP_MAC_START,
        DP_ROUND_ADV,
        DP_ADV_COMMIT,
        DP_PASS_RD,
        DP_PASS_LATCH,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    last;
        status_t status;
        logic    reject;
    } dp_cmd_t;

    typedef struct packed {
        logic eq_rates;
        logic due_busy;
        logic due_ok;
        logic ahead_ok;
        logic pass_more;
        logic ph_busy;
        logic mac_busy;
        logic adv_busy;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/spr_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// spr_datapath: resampler datapath
// Configuration, position counters, history and coefficient memories, the
// multiply-accumulate pipe, the dividers and the output register.
// ============================================================================
module spr_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spr_pkg::dp_cmd_t                     cmd,
    output spr_pkg::dp_status_t                  status,
    input  logic                                 cfg_wr_en,
    input  logic [spr_pkg::CFG_AW-1:0]           cfg_index,
    input  logic [spr_pkg::RATE_BITS-1:0]        cfg_data,
    input  logic [spr_pkg::SAMPLE_BITS-1:0]      in_sample,
    input  logic [spr_pkg::COEF_AW-1:0]          in_coef_index,
    input  logic [spr_pkg::COEF_BITS-1:0]        in_coef_value,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [spr_pkg::SAMPLE_BITS-1:0]      m_tdata,
    output logic                                 m_tlast,
    output logic [1:0]                           m_tuser
);

    localparam int HALF_CNT = spr_pkg::CNT_BITS / 2;
    localparam int MULX_BITS = spr_pkg::CNT_BITS + 1 - HALF_CNT;
    localparam int MULP_BITS = MULX_BITS + spr_pkg::RATE_BITS;
    localparam int DUE_BITS = MULP_BITS + HALF_CNT;
    localparam int ADV_BITS = spr_pkg::RATE_BITS + 1;
    localparam int ADV_CNT_BITS = $clog2(ADV_BITS + 1);
    localparam int PH_CNT_BITS = $clog2(spr_pkg::PHASE_BITS + 1);
    localparam int POS_BITS = spr_pkg::CNT_BITS + 2;
    localparam int PROD_BITS = spr_pkg::SAMPLE_BITS + spr_pkg::COEF_BITS;
    localparam logic signed [spr_pkg::ACC_BITS-1:0] RND_HALF =
        spr_pkg::ACC_BITS'(1) << (spr_pkg::COEF_FRAC - 1);
    localparam logic signed [spr_pkg::ACC_BITS-1:0] SAT_HI =
        spr_pkg::ACC_BITS'(2 ** (spr_pkg::SAMPLE_BITS - 1) - 1);
    localparam logic signed [spr_pkg::ACC_BITS-1:0] SAT_LO = ~SAT_HI;

    logic [spr_pkg::RATE_BITS-1:0] src_rate_reg;
    logic [spr_pkg::RATE_BITS-1:0] tgt_rate_reg;
    logic [spr_pkg::HALF_BITS-1:0] half_reg;
    logic [spr_pkg::RATE_BITS-1:0] from_rate;
    logic [spr_pkg::RATE_BITS-1:0] to_rate;
    logic [spr_pkg::HALF_BITS-1:0] half_eff;
    logic [spr_pkg::TAP_BITS-1:0]  taps;

    logic [spr_pkg::CNT_BITS-1:0]  in_cnt_reg;
    logic [spr_pkg::CNT_BITS-1:0]  out_cnt_reg;
    logic [spr_pkg::CNT_BITS-1:0]  idx_reg;
    logic [spr_pkg::RATE_BITS-1:0] frac_reg;

    logic [spr_pkg::SAMPLE_BITS-1:0] ring_mem [spr_pkg::HIST_DEPTH];
    logic [spr_pkg::COEF_BITS-1:0]   coef_mem [spr_pkg::COEF_DEPTH];
    logic signed [spr_pkg::SAMPLE_BITS-1:0] ring_rd_reg;
    logic signed [spr_pkg::COEF_BITS-1:0]   coef_rd_reg;
    logic [spr_pkg::HIST_AW-1:0] ring_addr;
    logic [spr_pkg::HIST_AW-1:0] mac_addr;

    logic [2:0]                  due_step_reg;
    logic [MULX_BITS-1:0]        mul_x;
    logic [spr_pkg::RATE_BITS-1:0] mul_y;
    logic [MULP_BITS-1:0]        mul_p_reg;
    logic [DUE_BITS-1:0]         due_a_reg;
    logic [DUE_BITS-1:0]         due_b_reg;
    logic [spr_pkg::CNT_BITS:0]  out_plus;

    logic [PH_CNT_BITS-1:0]        ph_cnt_reg;
    logic [ADV_BITS-1:0]           ph_rem_reg;
    logic [spr_pkg::PHASE_BITS-1:0] ph_q_reg;
    logic [ADV_BITS-1:0]           ph_shift;

    logic [spr_pkg::TAP_BITS-1:0]  tap_cnt_reg;
    logic signed [POS_BITS-1:0]    pos_reg;
    logic signed [POS_BITS-1:0]    last_pos;
    logic signed [POS_BITS-1:0]    pos_sel;
    logic [spr_pkg::COEF_AW-1:0]   ca_reg;
    logic                          rd_v_reg;
    logic                          pr_v_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [spr_pkg::ACC_BITS-1:0] acc_reg;
    logic signed [spr_pkg::ACC_BITS-1:0] rnd_sum;
    logic signed [spr_pkg::ACC_BITS-1:0] rnd_q;
    logic [spr_pkg::SAMPLE_BITS-1:0] rnd_sat;
    logic [spr_pkg::SAMPLE_BITS-1:0] held_reg;

    logic [ADV_CNT_BITS-1:0]       adv_cnt_reg;
    logic [ADV_BITS-1:0]           adv_dv_reg;
    logic [ADV_BITS-1:0]           adv_rem_reg;
    logic [ADV_BITS-1:0]           adv_q_reg;
    logic [ADV_BITS-1:0]           adv_shift;
    logic [spr_pkg::CNT_BITS:0]    idx_sum;

    logic                            m_valid_reg;
    logic [spr_pkg::SAMPLE_BITS-1:0] m_sample_reg;
    logic                            m_last_reg;
    logic [1:0]                      m_stat_reg;

    assign from_rate = (src_rate_reg == '0) ? spr_pkg::RATE_BITS'(1) : src_rate_reg;
    assign to_rate   = (tgt_rate_reg == '0) ? spr_pkg::RATE_BITS'(1) : tgt_rate_reg;

    always_comb
    begin
        if (half_reg == '0)
        begin
            half_eff = spr_pkg::HALF_BITS'(1);
        end
        else if (half_reg > spr_pkg::HALF_BITS'(spr_pkg::MAX_HALF))
        begin
            half_eff = spr_pkg::HALF_BITS'(spr_pkg::MAX_HALF);
        end
        else
        begin
            half_eff = half_reg;
        end
    end

    assign taps = spr_pkg::TAP_BITS'({half_eff, 1'b1});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_rate_reg <= spr_pkg::RATE_BITS'(48000);
            tgt_rate_reg <= spr_pkg::RATE_BITS'(16000);
            half_reg     <= spr_pkg::HALF_BITS'(8);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                spr_pkg::CFG_SOURCE_RATE: src_rate_reg <= cfg_data;
                spr_pkg::CFG_TARGET_RATE: tgt_rate_reg <= cfg_data;
                spr_pkg::CFG_HALF_WIDTH:  half_reg <= cfg_data[spr_pkg::HALF_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign idx_sum = {1'b0, idx_reg} + (spr_pkg::CNT_BITS + 1)'(adv_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            idx_reg     <= '0;
            frac_reg    <= '0;
        end
        else
        begin
            unique case (cmd.op)
                spr_pkg::DP_PUSH:
                begin
                    if (in_cnt_reg != spr_pkg::CNT_MAX)
                    begin
                        in_cnt_reg <= in_cnt_reg + spr_pkg::CNT_BITS'(1);
                    end
                end
                spr_pkg::DP_RESTART:
                begin
                    in_cnt_reg  <= '0;
                    out_cnt_reg <= '0;
                    idx_reg     <= '0;
                    frac_reg    <= '0;
                end
                spr_pkg::DP_SYNC_IDX:
                begin
                    idx_reg <= in_cnt_reg;
                end
                spr_pkg::DP_PASS_LATCH:
                begin
                    out_cnt_reg <= out_cnt_reg + spr_pkg::CNT_BITS'(1);
                end
                spr_pkg::DP_ADV_COMMIT:
                begin
                    idx_reg <= idx_sum[spr_pkg::CNT_BITS] ? spr_pkg::CNT_MAX
                                                          : idx_sum[spr_pkg::CNT_BITS-1:0];
                    frac_reg    <= adv_rem_reg[spr_pkg::RATE_BITS-1:0];
                    out_cnt_reg <= out_cnt_reg + spr_pkg::CNT_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    assign last_pos = $signed({2'b00, in_cnt_reg}) - POS_BITS'(1);

    always_comb
    begin
        pos_sel = (pos_reg > last_pos) ? last_pos : pos_reg;
        mac_addr = (pos_sel < 0) ? '0 : pos_sel[spr_pkg::HIST_AW-1:0];
    end

    assign ring_addr = (cmd.op == spr_pkg::DP_PASS_RD) ?
                       out_cnt_reg[spr_pkg::HIST_AW-1:0] : mac_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.op == spr_pkg::DP_PUSH)
        begin
            ring_mem[in_cnt_reg[spr_pkg::HIST_AW-1:0]] <= in_sample;
        end
        ring_rd_reg <= ring_mem[ring_addr];
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.op == spr_pkg::DP_COEF_WR) &&
            (in_coef_index < spr_pkg::COEF_AW'(spr_pkg::COEF_DEPTH)))
        begin
            coef_mem[in_coef_index] <= in_coef_value;
        end
        coef_rd_reg <= coef_mem[ca_reg];
    end

    assign out_plus = {1'b0, out_cnt_reg} + (spr_pkg::CNT_BITS + 1)'(1);

    always_comb
    begin
        unique case (due_step_reg)
            3'd1:
            begin
                mul_x = MULX_BITS'(in_cnt_reg[HALF_CNT-1:0]);
                mul_y = to_rate;
            end
            3'd2:
            begin
                mul_x = MULX_BITS'(in_cnt_reg[spr_pkg::CNT_BITS-1:HALF_CNT]);
                mul_y = to_rate;
            end
            3'd3:
            begin
                mul_x = MULX_BITS'(out_plus[HALF_CNT-1:0]);
                mul_y = from_rate;
            end
            3'd4:
            begin
                mul_x = out_plus[spr_pkg::CNT_BITS:HALF_CNT];
                mul_y = from_rate;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_step_reg <= '0;
        end
        else if (cmd.op == spr_pkg::DP_DUE_START)
        begin
            due_step_reg <= 3'd1;
        end
        else if (due_step_reg == 3'd5)
        begin
            due_step_reg <= '0;
        end
        else if (due_step_reg != '0)
        begin
            due_step_reg <= due_step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= {{spr_pkg::RATE_BITS{1'b0}}, mul_x} * {{MULX_BITS{1'b0}}, mul_y};
        unique case (due_step_reg)
            3'd2: due_a_reg <= DUE_BITS'(mul_p_reg);
            3'd3: due_a_reg <= due_a_reg + {mul_p_reg, {HALF_CNT{1'b0}}};
            3'd4: due_b_reg <= DUE_BITS'(mul_p_reg);
            3'd5: due_b_reg <= due_b_reg + {mul_p_reg, {HALF_CNT{1'b0}}};
            default: ;
        endcase
    end

    assign ph_shift = {ph_rem_reg[ADV_BITS-2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_cnt_reg <= '0;
        end
        else if (cmd.op == spr_pkg::DP_PH_START)
        begin
            ph_cnt_reg <= (frac_reg >= to_rate) ? '0 : PH_CNT_BITS'(spr_pkg::PHASE_BITS);
        end
        else if (ph_cnt_reg != '0)
        begin
            ph_cnt_reg <= ph_cnt_reg - PH_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spr_pkg::DP_PH_START)
        begin
            ph_rem_reg <= {1'b0, frac_reg};
            ph_q_reg   <= (frac_reg >= to_rate) ? spr_pkg::PHASE_BITS'(spr_pkg::PHASES - 1)
                                                : '0;
        end
        else if (ph_cnt_reg != '0)
        begin
            if (ph_shift >= {1'b0, to_rate})
            begin
                ph_rem_reg <= ph_shift - {1'b0, to_rate};
                ph_q_reg   <= {ph_q_reg[spr_pkg::PHASE_BITS-2:0], 1'b1};
            end
            else
            begin
                ph_rem_reg <= ph_shift;
                ph_q_reg   <= {ph_q_reg[spr_pkg::PHASE_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_cnt_reg <= '0;
            rd_v_reg    <= 1'b0;
            pr_v_reg    <= 1'b0;
        end
        else if (cmd.op == spr_pkg::DP_MAC_START)
        begin
            tap_cnt_reg <= taps;
            rd_v_reg    <= 1'b0;
            pr_v_reg    <= 1'b0;
        end
        else
        begin
            rd_v_reg <= (tap_cnt_reg != '0);
            pr_v_reg <= rd_v_reg;
            if (tap_cnt_reg != '0)
            begin
                tap_cnt_reg <= tap_cnt_reg - spr_pkg::TAP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spr_pkg::DP_MAC_START)
        begin
            pos_reg <= $signed({2'b00, idx_reg}) - $signed(POS_BITS'(half_eff));
            ca_reg  <= spr_pkg::COEF_AW'(
                {{(spr_pkg::COEF_AW - spr_pkg::PHASE_BITS){1'b0}}, ph_q_reg} *
                {{(spr_pkg::COEF_AW - spr_pkg::TAP_BITS){1'b0}}, taps});
            acc_reg <= '0;
        end
        else
        begin
            if (tap_cnt_reg != '0)
            begin
                pos_reg <= pos_reg + POS_BITS'(1);
                ca_reg  <= ca_reg + spr_pkg::COEF_AW'(1);
            end
            if (pr_v_reg)
            begin
                acc_reg <= acc_reg + spr_pkg::ACC_BITS'(prod_reg);
            end
        end
        prod_reg <= ring_rd_reg * coef_rd_reg;
    end

    always_comb
    begin
        rnd_sum = acc_reg + RND_HALF;
        rnd_q   = rnd_sum >>> spr_pkg::COEF_FRAC;
        if (rnd_q > SAT_HI)
        begin
            rnd_sat = SAT_HI[spr_pkg::SAMPLE_BITS-1:0];
        end
        else if (rnd_q < SAT_LO)
        begin
            rnd_sat = SAT_LO[spr_pkg::SAMPLE_BITS-1:0];
        end
        else
        begin
            rnd_sat = rnd_q[spr_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spr_pkg::DP_ROUND_ADV)
        begin
            held_reg <= rnd_sat;
        end
        else if (cmd.op == spr_pkg::DP_PASS_LATCH)
        begin
            held_reg <= ring_rd_reg;
        end
    end

    assign adv_shift = {adv_rem_reg[ADV_BITS-2:0], adv_dv_reg[ADV_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_cnt_reg <= '0;
        end
        else if (cmd.op == spr_pkg::DP_ROUND_ADV)
        begin
            adv_cnt_reg <= ADV_CNT_BITS'(ADV_BITS);
        end
        else if (adv_cnt_reg != '0)
        begin
            adv_cnt_reg <= adv_cnt_reg - ADV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spr_pkg::DP_ROUND_ADV)
        begin
            adv_dv_reg  <= {1'b0, frac_reg} + {1'b0, from_rate};
            adv_rem_reg <= '0;
            adv_q_reg   <= '0;
        end
        else if (adv_cnt_reg != '0)
        begin
            adv_dv_reg <= {adv_dv_reg[ADV_BITS-2:0], 1'b0};
            if (adv_shift >= {1'b0, to_rate})
            begin
                adv_rem_reg <= adv_shift - {1'b0, to_rate};
                adv_q_reg   <= {adv_q_reg[ADV_BITS-2:0], 1'b1};
            end
            else
            begin
                adv_rem_reg <= adv_shift;
                adv_q_reg   <= {adv_q_reg[ADV_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.op == spr_pkg::DP_EMIT)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == spr_pkg::DP_EMIT)
        begin
            m_sample_reg <= cmd.reject ? '0 : held_reg;
            m_last_reg   <= cmd.last;
            m_stat_reg   <= cmd.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_stat_reg;

    always_comb
    begin
        status.eq_rates  = (from_rate == to_rate);
        status.due_busy  = (due_step_reg != '0);
        status.due_ok    = (due_b_reg <= due_a_reg) && (out_cnt_reg != spr_pkg::CNT_MAX);
        status.ahead_ok  = (({1'b0, idx_reg} + (spr_pkg::CNT_BITS + 1)'(half_eff)) <
                            {1'b0, in_cnt_reg});
        status.pass_more = (out_cnt_reg < in_cnt_reg);
        status.ph_busy   = (ph_cnt_reg != '0);
        status.mac_busy  = (tap_cnt_reg != '0) || rd_v_reg || pr_v_reg;
        status.adv_busy  = (adv_cnt_reg != '0);
        status.out_free  = !m_valid_reg || m_tready;
    end

endmodule

// File: src/spr_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// spr_ctrl: resampler sequencer
// Decodes each transaction and steps the datapath through every output.
// ============================================================================
module spr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  spr_pkg::command_t     command,
    output spr_pkg::dp_cmd_t      dp_cmd,
    input  spr_pkg::dp_status_t   dp_status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REJECT,
        ST_CHECK,
        ST_PASS_CHECK,
        ST_PASS_RD,
        ST_PASS_LATCH,
        ST_DUE_WAIT,
        ST_EMIT,
        ST_PH_GO,
        ST_PH_WAIT,
        ST_MAC_WAIT,
        ST_ADV_WAIT
    } state_t;

    state_t                        state_reg, state_next;
    logic                          flushed_reg, flushed_next;
    logic                          finish_reg, finish_next;
    logic                          have_reg, have_next;
    logic [spr_pkg::RUN_BITS-1:0]  run_cnt_reg, run_cnt_next;
    logic                          em_last_reg, em_last_next;
    spr_pkg::status_t              em_stat_reg, em_stat_next;
    logic                          run_full;
    logic                          go;

    assign run_full = (run_cnt_reg == spr_pkg::RUN_BITS'(spr_pkg::MAX_RUN));
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        flushed_next = flushed_reg;
        finish_next  = finish_reg;
        have_next    = have_reg;
        run_cnt_next = run_cnt_reg;
        em_last_next = em_last_reg;
        em_stat_next = em_stat_reg;
        dp_cmd       = '{op: spr_pkg::DP_NOP, last: 1'b0,
                         status: spr_pkg::STAT_OK, reject: 1'b0};
        go           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (command)
                        spr_pkg::CMD_PUSH:
                        begin
                            if (flushed_reg)
                            begin
                                state_next = ST_REJECT;
                            end
                            else
                            begin
                                dp_cmd.op    = spr_pkg::DP_PUSH;
                                finish_next  = 1'b0;
                                have_next    = 1'b0;
                                run_cnt_next = '0;
                                state_next   = ST_CHECK;
                            end
                        end
                        spr_pkg::CMD_FLUSH:
                        begin
                            flushed_next = 1'b1;
                            finish_next  = 1'b1;
                            have_next    = 1'b0;
                            run_cnt_next = '0;
                            state_next   = ST_CHECK;
                        end
                        spr_pkg::CMD_RESTART:
                        begin
                            dp_cmd.op    = spr_pkg::DP_RESTART;
                            flushed_next = 1'b0;
                        end
                        spr_pkg::CMD_COEF_WR:
                        begin
                            dp_cmd.op = spr_pkg::DP_COEF_WR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_REJECT:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd = '{op: spr_pkg::DP_EMIT, last: 1'b1,
                               status: spr_pkg::STAT_REJECT, reject: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (dp_status.eq_rates)
                begin
                    dp_cmd.op  = spr_pkg::DP_SYNC_IDX;
                    state_next = ST_PASS_CHECK;
                end
                else
                begin
                    dp_cmd.op  = spr_pkg::DP_DUE_START;
                    state_next = ST_DUE_WAIT;
                end
            end
            ST_PASS_CHECK:
            begin
                go = dp_status.pass_more;
                if (have_reg)
                begin
                    em_last_next = !go || run_full;
                    em_stat_next = (go && run_full) ? spr_pkg::STAT_TRUNC : spr_pkg::STAT_OK;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    state_next = go ? ST_PASS_RD : ST_IDLE;
                end
            end
            ST_PASS_RD:
            begin
                dp_cmd.op  = spr_pkg::DP_PASS_RD;
                state_next = ST_PASS_LATCH;
            end
            ST_PASS_LATCH:
            begin
                dp_cmd.op    = spr_pkg::DP_PASS_LATCH;
                have_next    = 1'b1;
                run_cnt_next = run_cnt_reg + spr_pkg::RUN_BITS'(1);
                state_next   = ST_PASS_CHECK;
            end
            ST_DUE_WAIT:
            begin
                go = dp_status.due_ok && (finish_reg || dp_status.ahead_ok);
                if (!dp_status.due_busy)
                begin
                    if (have_reg)
                    begin
                        em_last_next = !go || run_full;
                        em_stat_next = (go && run_full) ? spr_pkg::STAT_TRUNC
                                                        : spr_pkg::STAT_OK;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        state_next = go ? ST_PH_GO : ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd = '{op: spr_pkg::DP_EMIT, last: em_last_reg,
                               status: em_stat_reg, reject: 1'b0};
                    have_next = 1'b0;
                    if (em_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = dp_status.eq_rates ? ST_PASS_RD : ST_PH_GO;
                    end
                end
            end
            ST_PH_GO:
            begin
                dp_cmd.op  = spr_pkg::DP_PH_START;
                state_next = ST_PH_WAIT;
            end
            ST_PH_WAIT:
            begin
                if (!dp_status.ph_busy)
                begin
                    dp_cmd.op  = spr_pkg::DP_MAC_START;
                    state_next = ST_MAC_WAIT;
                end
            end
            ST_MAC_WAIT:
            begin
                if (!dp_status.mac_busy)
                begin
                    dp_cmd.op  = spr_pkg::DP_ROUND_ADV;
                    state_next = ST_ADV_WAIT;
                end
            end
            ST_ADV_WAIT:
            begin
                if (!dp_status.adv_busy)
                begin
                    dp_cmd.op    = spr_pkg::DP_ADV_COMMIT;
                    have_next    = 1'b1;
                    run_cnt_next = run_cnt_reg + spr_pkg::RUN_BITS'(1);
                    state_next   = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            flushed_reg <= 1'b0;
            finish_reg  <= 1'b0;
            have_reg    <= 1'b0;
            run_cnt_reg <= '0;
            em_last_reg <= 1'b0;
            em_stat_reg <= spr_pkg::STAT_OK;
        end
        else
        begin
            state_reg   <= state_next;
            flushed_reg <= flushed_next;
            finish_reg  <= finish_next;
            have_reg    <= have_next;
            run_cnt_reg <= run_cnt_next;
            em_last_reg <= em_last_next;
            em_stat_reg <= em_stat_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == spr_pkg::DP_EMIT) |-> dp_status.out_free)
        else $error("Result written while the output register is occupied.");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_cnt_reg <= spr_pkg::RUN_BITS'(spr_pkg::MAX_RUN))
        else $error("Run length exceeded its limit.");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |->
        (!dp_status.mac_busy && !dp_status.adv_busy && !dp_status.due_busy))
        else $error("Datapath unit busy while the sequencer is idle.");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (command == spr_pkg::CMD_RESTART)) |=> !flushed_reg)
        else $error("Flush mark survived a restart.");
`endif

endmodule

// File: src/streaming_polyphase_resampler.sv
`timescale 1ns / 1ps
// ============================================================================
// streaming_polyphase_resampler: streaming rational sample-rate converter
// Polyphase windowed-sinc interpolation with exact position counters.
// ============================================================================
// A push or flush with no due output frees the input after the due check, without filtering.
// Each filtered output runs the due check on a shared 25x18 multiplier, the
// 6-step phase divider, one tap per cycle in the MAC pipe and the 19-step
// position divider. Equal rates pass samples through unfiltered, by a history read and a latch.
// One transaction is processed at a time; the output register holds one result.
// Reset clears the counters and control and loads 48000, 16000 and 8; memories keep data.
module streaming_polyphase_resampler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_in[15:0], coef_index[28:16], coef_value[46:29]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample_out[15:0]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    spr_pkg::dp_cmd_t    dp_cmd;
    spr_pkg::dp_status_t dp_status;
    spr_pkg::command_t   command;

    assign command = spr_pkg::command_t'(s_tuser);

    spr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .command   (command),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    spr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_sample     (s_tdata[15:0]),
        .in_coef_index (s_tdata[28:16]),
        .in_coef_value (s_tdata[46:29]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser)
    );

endmodule
